FILE: hdl/assert_macros.svh
// Assertion helper macros for the friction cone evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define FCCE_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/fcce_pkg.sv
// Shared types, constants and saturation helper for the friction cone evaluator.
`timescale 1ns / 1ps

package fcce_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int RAD_W_DEF     = 2 * DATA_W;
    localparam int SAT_W         = 72;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFF  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THRESHOLD = 1'b1;

    localparam logic [DATA_W-2:0]        MU_RESET  = 31'd32768;
    localparam logic signed [DATA_W-1:0] THR_RESET = 32'sd0;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic signed [DATA_W-1:0] normal_x;
        logic signed [DATA_W-1:0] normal_y;
        logic signed [DATA_W-1:0] normal_z;
    } fcce_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] unilateral_value;
        logic signed [DATA_W-1:0] cone_value;
        logic signed [DATA_W-1:0] jac_unilateral_x;
        logic signed [DATA_W-1:0] jac_unilateral_y;
        logic signed [DATA_W-1:0] jac_unilateral_z;
        logic signed [DATA_W-1:0] jac_cone_x;
        logic signed [DATA_W-1:0] jac_cone_y;
        logic signed [DATA_W-1:0] jac_cone_z;
        logic                     degenerate;
    } fcce_out_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SAT_W-1:DATA_W-1];
        hi_zeros = ~|v[SAT_W-1:DATA_W-1];
        if (hi_ones || hi_zeros)
        begin
            return v[DATA_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: hdl/fcce_isqrt.sv
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps

module fcce_isqrt import fcce_pkg::*; #(
    parameter int RAD_W = RAD_W_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic [RAD_W-1:0]   rad,
    output logic [RAD_W/2-1:0] root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  cat;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // trial subtract of 4*root + 1
        assign cat   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REM_W'(cat - trial) : REM_W'(cat);
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
            end
        end

        if (k < ROOT_W - 1)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k] <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

FILE: hdl/fcce_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module fcce_div import fcce_pkg::*; #(
    parameter int DIVD_W = DATA_W + FRAC_BITS_DEF,
    parameter int DIVS_W = DATA_W
) (
    input  logic              clk,
    input  logic              en,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVS_W-1:0] rem_reg [DIVD_W];
    logic [DIVD_W-1:0] acc_reg [DIVD_W];
    logic [DIVS_W-1:0] den_reg [DIVD_W-1];

    for (genvar k = 0; k < DIVD_W; k++)
    begin : g_stage
        logic [DIVS_W-1:0] rem_in;
        logic [DIVD_W-1:0] acc_in;
        logic [DIVS_W-1:0] den_in;
        logic [DIVS_W:0]   cat;
        logic              ge;

        if (k == 0)
        begin : g_head
            assign rem_in = '0;
            assign acc_in = dividend;
            assign den_in = divisor;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[k-1];
            assign acc_in = acc_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // bring down next dividend bit, subtract when it fits
        assign cat = {rem_in, acc_in[DIVD_W-1]};
        assign ge  = (cat >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DIVS_W'(cat - {1'b0, den_in}) : DIVS_W'(cat);
                acc_reg[k] <= {acc_in[DIVD_W-2:0], ge};
            end
        end

        if (k < DIVD_W - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quotient = acc_reg[DIVD_W-1];

endmodule

FILE: hdl/friction_cone_constraint_eval_top.sv
// Friction cone constraint evaluator top level: deep arithmetic pipeline.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  in      | in_valid / in_ready    | in_data  (fcce_in_t)
//  out     | out_valid / out_ready  | out_data (fcce_out_t)
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// One item enters per cycle unless the output stalls; it passes the front
// stages, the 32-stage square root, the divider and the output register.
// The whole pipeline advances when the output register is empty or drained,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module friction_cone_constraint_eval_top import fcce_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fcce_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fcce_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int W       = DATA_W;
    localparam int PW      = 2 * W;
    localparam int DIVD_W  = W + FRAC_BITS;
    localparam int SQ_LAT  = PW / 2;
    localparam int DIV_LAT = DIVD_W;

    typedef struct packed {
        logic [2:0]                 neg;
        logic [2:0][W-1:0]          mag;
        logic [PW-1:0]              mudq;
        logic [2:0][PW-1:0]         mubq;
        logic [2:0][W-1:0]          ju;
        logic [W-1:0]               uni;
    } carry_t;

    typedef struct packed {
        carry_t       c;
        logic [W-1:0] nrm;
    } carry_n_t;

    // ---------------------------------------------------------------
    // configuration registers
    logic [W-2:0]        mu_reg;
    logic signed [W-1:0] thr_reg;
    logic signed [W-1:0] mu_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg  <= MU_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRICTION_COEFF:  mu_reg  <= cfg_data[W-2:0];
                CFG_FORCE_THRESHOLD: thr_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign mu_s = signed'({1'b0, mu_reg});

    // ---------------------------------------------------------------
    // global advance: output register empty or being drained
    logic      advance;
    logic      out_valid_reg;
    fcce_out_t out_data_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ---------------------------------------------------------------
    // stage 1: F_i * n_i
    logic signed [W-1:0] f_in [3];
    logic signed [W-1:0] n_in [3];

    assign f_in[0] = in_data.force_x;
    assign f_in[1] = in_data.force_y;
    assign f_in[2] = in_data.force_z;
    assign n_in[0] = in_data.normal_x;
    assign n_in[1] = in_data.normal_y;
    assign n_in[2] = in_data.normal_z;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic                 m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    logic signed [W-1:0]  f1_reg [3], f2_reg [3], f3_reg [3], f4_reg [3], f5_reg [3];
    logic signed [W-1:0]  f6_reg [3];
    logic signed [W-1:0]  n1_reg [3], n2_reg [3], n3_reg [3], n4_reg [3], n5_reg [3];
    logic signed [W-1:0]  n6_reg [3];
    logic signed [PW-1:0] fn1_reg [3];

    // valid bits for the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg <= in_data.mode;
            for (int i = 0; i < 3; i++)
            begin
                f1_reg[i]  <= f_in[i];
                n1_reg[i]  <= n_in[i];
                fn1_reg[i] <= f_in[i] * n_in[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: d = sat(sum of floor-shifted products)
    logic signed [SAT_W-1:0] d_sum;
    logic signed [W-1:0]     d2_reg;

    assign d_sum = SAT_W'(fn1_reg[0] >>> FRAC_BITS) + SAT_W'(fn1_reg[1] >>> FRAC_BITS)
                 + SAT_W'(fn1_reg[2] >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m2_reg <= m1_reg;
            f2_reg <= f1_reg;
            n2_reg <= n1_reg;
            d2_reg <= sat32(d_sum);
        end
    end

    // ---------------------------------------------------------------
    // stage 3: n_i * d
    logic signed [W-1:0]  d3_reg;
    logic signed [PW-1:0] nd3_reg [3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m3_reg <= m2_reg;
            f3_reg <= f2_reg;
            n3_reg <= n2_reg;
            d3_reg <= d2_reg;
            for (int i = 0; i < 3; i++)
            begin
                nd3_reg[i] <= n2_reg[i] * d2_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 4: tangential part t_i
    logic signed [W-1:0] d4_reg;
    logic signed [W-1:0] t4_reg [3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m4_reg <= m3_reg;
            f4_reg <= f3_reg;
            n4_reg <= n3_reg;
            d4_reg <= d3_reg;
            for (int i = 0; i < 3; i++)
            begin
                t4_reg[i] <= sat32(SAT_W'(f3_reg[i]) - SAT_W'(nd3_reg[i] >>> FRAC_BITS));
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 5: squares, n.t terms, mu products, row 0 results
    logic signed [W-1:0]  base4 [3];
    logic signed [W-1:0]  d5_reg;
    logic signed [W-1:0]  t5_reg [3];
    logic signed [PW-1:0] sq5_reg [3];
    logic signed [PW-1:0] nt5_reg [3];
    logic signed [PW-1:0] mud5_reg;
    logic signed [PW-1:0] mub5_reg [3];
    logic signed [W-1:0]  ju5_reg [3];
    logic signed [W-1:0]  uni5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            base4[i] = m4_reg ? f4_reg[i] : n4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m5_reg   <= m4_reg;
            f5_reg   <= f4_reg;
            n5_reg   <= n4_reg;
            d5_reg   <= d4_reg;
            t5_reg   <= t4_reg;
            mud5_reg <= mu_s * d4_reg;
            uni5_reg <= sat32(SAT_W'(thr_reg) - SAT_W'(d4_reg));
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i]  <= t4_reg[i] * t4_reg[i];
                nt5_reg[i]  <= n4_reg[i] * t4_reg[i];
                mub5_reg[i] <= mu_s * base4[i];
                ju5_reg[i]  <= sat32(-SAT_W'(base4[i]));
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 6: sum of squares, p = n.t, mu products shifted
    logic signed [SAT_W-1:0] p_sum;
    logic [PW-1:0]           ss_sum;
    logic signed [W-1:0]     d6_reg;
    logic signed [W-1:0]     t6_reg [3];
    logic [PW-1:0]           ss6_reg;
    logic signed [W-1:0]     p6_reg;
    logic signed [PW-1:0]    mudq6_reg;
    logic signed [PW-1:0]    mubq6_reg [3];
    logic signed [W-1:0]     ju6_reg [3];
    logic signed [W-1:0]     uni6_reg;

    assign p_sum  = SAT_W'(nt5_reg[0] >>> FRAC_BITS) + SAT_W'(nt5_reg[1] >>> FRAC_BITS)
                  + SAT_W'(nt5_reg[2] >>> FRAC_BITS);
    assign ss_sum = unsigned'(sq5_reg[0]) + unsigned'(sq5_reg[1]) + unsigned'(sq5_reg[2]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m6_reg    <= m5_reg;
            f6_reg    <= f5_reg;
            n6_reg    <= n5_reg;
            d6_reg    <= d5_reg;
            t6_reg    <= t5_reg;
            ss6_reg   <= ss_sum;
            p6_reg    <= sat32(p_sum);
            mudq6_reg <= mud5_reg >>> FRAC_BITS;
            ju6_reg   <= ju5_reg;
            uni6_reg  <= uni5_reg;
            for (int i = 0; i < 3; i++)
            begin
                mubq6_reg[i] <= mub5_reg[i] >>> FRAC_BITS;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 7: numerator products
    logic signed [W-1:0]  t7_reg [3];
    logic [PW-1:0]        ss7_reg;
    logic signed [PW-1:0] a7_reg [3];
    logic signed [PW-1:0] b7_reg [3];
    logic signed [PW-1:0] mudq7_reg;
    logic signed [PW-1:0] mubq7_reg [3];
    logic signed [W-1:0]  ju7_reg [3];
    logic signed [W-1:0]  uni7_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m7_reg    <= m6_reg;
            t7_reg    <= t6_reg;
            ss7_reg   <= ss6_reg;
            mudq7_reg <= mudq6_reg;
            mubq7_reg <= mubq6_reg;
            ju7_reg   <= ju6_reg;
            uni7_reg  <= uni6_reg;
            for (int i = 0; i < 3; i++)
            begin
                a7_reg[i] <= m6_reg ? (t6_reg[i] * d6_reg) : (n6_reg[i] * p6_reg);
                b7_reg[i] <= f6_reg[i] * p6_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 8: saturated numerators as sign and magnitude
    logic signed [W-1:0] num7 [3];
    logic [PW-1:0]       ss8_reg;
    carry_t              c8_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (m7_reg)
            begin
                num7[i] = sat32(-(SAT_W'(a7_reg[i] >>> FRAC_BITS)
                                + SAT_W'(b7_reg[i] >>> FRAC_BITS)));
            end
            else
            begin
                num7[i] = sat32(SAT_W'(t7_reg[i]) - SAT_W'(a7_reg[i] >>> FRAC_BITS));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ss8_reg     <= ss7_reg;
            c8_reg.mudq <= mudq7_reg;
            c8_reg.uni  <= uni7_reg;
            for (int i = 0; i < 3; i++)
            begin
                c8_reg.neg[i]  <= num7[i][W-1];
                c8_reg.mag[i]  <= num7[i][W-1] ? W'(-num7[i]) : W'(num7[i]);
                c8_reg.mubq[i] <= mubq7_reg[i];
                c8_reg.ju[i]   <= ju7_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // square root, with payload delay line alongside
    logic [W-1:0] nrm;
    logic         va_reg [SQ_LAT];
    carry_t       ca_reg [SQ_LAT];

    fcce_isqrt #(
        .RAD_W (PW)
    ) u_isqrt (
        .clk  (clk),
        .en   (advance),
        .rad  (ss8_reg),
        .root (nrm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_LAT; k++)
            begin
                va_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            va_reg[0] <= v8_reg;
            for (int k = 1; k < SQ_LAT; k++)
            begin
                va_reg[k] <= va_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ca_reg[0] <= c8_reg;
            for (int k = 1; k < SQ_LAT; k++)
            begin
                ca_reg[k] <= ca_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // three dividers, with payload delay line alongside
    carry_t            ca_last;
    logic [DIVD_W-1:0] quo [3];
    logic              vb_reg [DIV_LAT];
    carry_n_t          cb_reg [DIV_LAT];

    assign ca_last = ca_reg[SQ_LAT-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        fcce_div #(
            .DIVD_W (DIVD_W),
            .DIVS_W (W)
        ) u_div (
            .clk      (clk),
            .en       (advance),
            .dividend ({ca_last.mag[i], {FRAC_BITS{1'b0}}}),
            .divisor  (nrm),
            .quotient (quo[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vb_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vb_reg[0] <= va_reg[SQ_LAT-1];
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vb_reg[k] <= vb_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cb_reg[0].c   <= ca_last;
            cb_reg[0].nrm <= nrm;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                cb_reg[k] <= cb_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // final stage: signed quotients, cone row, saturation
    carry_n_t                cb_last;
    logic                    degen;
    logic signed [SAT_W-1:0] qv [3];
    logic signed [W-1:0]     jc [3];
    logic signed [W-1:0]     cone;
    fcce_out_t               res;

    assign cb_last = cb_reg[DIV_LAT-1];
    assign degen   = (cb_last.nrm == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = SAT_W'(signed'({1'b0, quo[i]}));
            if (cb_last.c.neg[i])
            begin
                qv[i] = -qv[i];
            end
            if (degen)
            begin
                qv[i] = '0;
            end
            jc[i] = sat32(qv[i] - SAT_W'(signed'(cb_last.c.mubq[i])));
        end
        cone = sat32(SAT_W'(signed'({1'b0, cb_last.nrm})) - SAT_W'(signed'(cb_last.c.mudq)));

        res.unilateral_value = signed'(cb_last.c.uni);
        res.cone_value       = cone;
        res.jac_unilateral_x = signed'(cb_last.c.ju[0]);
        res.jac_unilateral_y = signed'(cb_last.c.ju[1]);
        res.jac_unilateral_z = signed'(cb_last.c.ju[2]);
        res.jac_cone_x       = jc[0];
        res.jac_cone_y       = jc[1];
        res.jac_cone_z       = jc[2];
        res.degenerate       = degen;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= vb_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------
    // assertions
    `FCCE_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1_reg,
        "accepted transfer did not enter the first stage")
    `FCCE_ASSERT_NEXT(a_idle_no_entry, !in_valid && advance, !v1_reg,
        "first stage filled without a transfer")
    `FCCE_ASSERT_NEXT(a_stall_freezes, !advance,
        $stable(v8_reg) && $stable(va_reg[SQ_LAT-1]) && $stable(vb_reg[DIV_LAT-1]),
        "pipeline moved during an output stall")

endmodule
